// ===== hdl/pbkdf2_hmac_sha512_key_derivation_unit_defines.svh =====
// Assertion macros shared by the key derivation unit.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PBKDF2_HMAC_SHA512_KEY_DERIVATION_UNIT_DEFINES_SVH
`define PBKDF2_HMAC_SHA512_KEY_DERIVATION_UNIT_DEFINES_SVH

// same-cycle implication
`define PBK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pbkdf_pkg.sv =====
package pbkdf_pkg;

  typedef logic [63:0]       word_t;
  typedef logic [7:0][63:0]  hash_t;
  typedef logic [15:0][63:0] blk_t;

  // one input beat
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       segment_last;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // compression jobs
  typedef enum logic [2:0] {
    OP_PW, OP_IPAD, OP_OPAD, OP_TAIL, OP_OUTER, OP_INNER
  } op_t;

  // back end sequencer
  typedef enum logic [4:0] {
    ST_IDLE, ST_ITEM, ST_PUT, ST_CLOSE, ST_CL_PAD, ST_CL_CHK, ST_CL_LEN, ST_CL_GO,
    ST_IPAD, ST_OPAD, ST_PWCLR, ST_DRV, ST_BLK, ST_RD, ST_WR, ST_TAIL_GO,
    ST_PAD, ST_PAD_CHK, ST_LEN, ST_LEN_GO, ST_OUT_GO, ST_ACC, ST_IN_GO, ST_EMIT,
    ST_DONE, ST_WAIT
  } st_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic ACT_PASSWORD = 1'b0;
  localparam logic ACT_SALT     = 1'b1;

  localparam logic CFG_ITER   = 1'b0;
  localparam logic CFG_KEYLEN = 1'b1;

  localparam logic [31:0] ITER_RESET   = 32'd2048;
  localparam logic [9:0]  KEYLEN_RESET = 10'd64;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam hash_t SHA_IV = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam word_t RK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t sml_sig0(word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t sml_sig1(word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // OR a byte into a big-endian block at byte position pos
  function automatic blk_t put_byte(blk_t b, logic [6:0] pos, logic [7:0] v);
    blk_t r;
    r = b;
    r[pos[6:3]] = b[pos[6:3]] | ({v, 56'h0} >> {pos[2:0], 3'b000});
    return r;
  endfunction

  // final block of a hash whose message after the pad block is one digest
  function automatic blk_t h64_block(hash_t h);
    blk_t r;
    r      = '0;
    r[7:0] = h;
    r[8]   = 64'h8000_0000_0000_0000;
    r[15]  = 64'd1536;
    return r;
  endfunction

  function automatic blk_t xor_pad(blk_t k, logic [7:0] p);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[i] = k[i] ^ {8{p}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/pbkdf_ram.sv =====
module pbkdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pbkdf_front.sv =====
`include "pbkdf2_hmac_sha512_key_derivation_unit_defines.svh"

module pbkdf_front import pbkdf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  item_t  in_item,
  output logic   busy,
  input  logic   pop,
  output qhead_t head
);

  localparam int QPW = $clog2(QUEUE_DEPTH);

  item_t          mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QPW:0]   cnt_r;
  logic           push;

  // accept while the queue has room
  assign busy = (cnt_r == (QPW+1)'(QUEUE_DEPTH));
  assign push = start && !busy;

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `PBK_ASSERT_IMP(a_pop_nonempty, pop, cnt_r != '0, "pop from empty queue")
  `PBK_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= (QPW+1)'(QUEUE_DEPTH), "queue count overrun")
  `PBK_ASSERT_NXT(a_cnt_grow, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count lost")

endmodule

// ===== hdl/pbkdf_sha_core.sv =====
module pbkdf_sha_core import pbkdf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  hash_t h_in,
  input  blk_t  blk_in,
  output logic  done,
  output hash_t digest
);

  logic       run_r, fin_r, done_r;
  logic [6:0] rnd_r;
  hash_t      hin_r, st_r, dig_r;
  blk_t       w_r;
  word_t      t1, t2, w_new;
  hash_t      st_step;

  // one SHA-512 round per cycle
  always_comb begin
    t1 = st_r[7] + big_sig1(st_r[4]) + ((st_r[4] & st_r[5]) ^ (~st_r[4] & st_r[6]))
         + RK[rnd_r] + w_r[0];
    t2 = big_sig0(st_r[0])
         + ((st_r[0] & st_r[1]) ^ (st_r[0] & st_r[2]) ^ (st_r[1] & st_r[2]));
    st_step    = {st_r[6:4], st_r[3] + t1, st_r[2:0], t1 + t2};
    w_new      = w_r[0] + sml_sig0(w_r[1]) + w_r[9] + sml_sig1(w_r[14]);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hin_r <= h_in;
      st_r  <= h_in;
      w_r   <= blk_in;
    end else if (run_r) begin
      st_r <= st_step;
      w_r  <= {w_new, w_r[15:1]};
    end
    if (fin_r) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= hin_r[i] + st_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      fin_r  <= run_r && (rnd_r == 7'd79);
      done_r <= fin_r;
      if (start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 1'b1;
        if (rnd_r == 7'd79) run_r <= 1'b0;
      end
    end
  end

  assign done   = done_r;
  assign digest = dig_r;

endmodule

// ===== hdl/pbkdf_back.sv =====
`include "pbkdf2_hmac_sha512_key_derivation_unit_defines.svh"

module pbkdf_back import pbkdf_pkg::*; #(
  parameter int SALT_BYTES    = 256,
  parameter int MAX_KEY_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  qhead_t      head,
  output logic        pop,
  input  logic [31:0] iter_count,
  input  logic [9:0]  key_len,
  output logic        out_valid,
  output logic [63:0] out_key_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_result_last,
  output logic        out_salt_overflow
);

  localparam int AW  = $clog2(SALT_BYTES);
  localparam int SCW = $clog2(SALT_BYTES + 1);
  localparam int LW  = SCW + 1;

  st_t          st_r, st_nxt, ret_r, ret_nxt;
  op_t          op_r, op_sel;
  item_t        item_r;
  blk_t         kb_r, msg_r, key_blk, core_blk;
  hash_t        chain_r, imid_r, omid_r, inner_r, u_r, t_r, core_h, digest;
  logic [31:0]  pwc_r, ic_r;
  logic         longk_r, ovf_r, first_r;
  logic [SCW-1:0] sc_r;
  logic [6:0]   pos_r;
  logic [LW-1:0] idx_r, msg_len;
  logic [3:0]   bnum_r, blocks;
  logic [2:0]   j_r;
  logic [9:0]   len_sat, off, left;
  logic         core_start, core_done, ram_we, emit_now;
  logic         pw_need, pw_long, sc_room;
  logic [6:0]   pw_rem;
  logic [7:0]   ram_rdata, salt_byte;
  logic [AW-1:0] ram_raddr;
  logic         out_valid_r, out_last_r, out_ovf_r;
  logic [63:0]  out_word_r;
  logic [3:0]   out_vb_r;

  // derived quantities
  assign len_sat = (key_len > 10'(MAX_KEY_BYTES)) ? 10'(MAX_KEY_BYTES) : key_len;
  assign blocks  = 4'((len_sat + 10'd63) >> 6);
  assign pw_need = (pwc_r != '0) && (pwc_r[6:0] == 7'd0);
  assign pw_long = (pwc_r > 32'd128);
  assign pw_rem  = pwc_r[6:0];
  assign sc_room = (sc_r < SCW'(SALT_BYTES));
  assign msg_len = LW'(sc_r) + LW'(4);
  assign off     = 10'({3'(bnum_r - 4'd1), j_r, 3'b000});
  assign left    = len_sat - off;
  assign emit_now = (st_r == ST_EMIT) && (off < len_sat);
  assign salt_byte = (idx_r < LW'(sc_r)) ? ram_rdata :
                     ((idx_r == LW'(sc_r) + LW'(3)) ? {4'b0000, bnum_r} : 8'h00);

  // HMAC key: short password as is, long one as its digest
  assign key_blk = longk_r ? {512'b0, chain_r} : kb_r;

  // compressor operand selection
  always_comb begin
    case (op_sel)
      OP_PW:    begin core_h = chain_r; core_blk = kb_r; end
      OP_IPAD:  begin core_h = SHA_IV;  core_blk = xor_pad(key_blk, IPAD_BYTE); end
      OP_OPAD:  begin core_h = SHA_IV;  core_blk = xor_pad(key_blk, OPAD_BYTE); end
      OP_TAIL:  begin core_h = inner_r; core_blk = msg_r; end
      OP_OUTER: begin core_h = omid_r;  core_blk = h64_block(inner_r); end
      OP_INNER: begin core_h = imid_r;  core_blk = h64_block(u_r); end
      default:  begin core_h = chain_r; core_blk = kb_r; end
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop        = 1'b0;
    core_start = 1'b0;
    op_sel     = OP_PW;
    ram_we     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    case (st_r)
      ST_IDLE: pop = head.valid;
      ST_ITEM: begin
        if (item_r.action == ACT_PASSWORD) begin
          core_start = item_r.has_byte && pw_need;
        end else begin
          ram_we = item_r.has_byte && sc_room;
        end
      end
      ST_CLOSE:   core_start = pw_long && (pw_rem == 7'd0);
      ST_CL_CHK:  core_start = (pw_rem >= 7'd112);
      ST_CL_GO:   core_start = 1'b1;
      ST_IPAD:    begin core_start = 1'b1; op_sel = OP_IPAD; end
      ST_OPAD:    begin core_start = 1'b1; op_sel = OP_OPAD; end
      ST_TAIL_GO: begin core_start = 1'b1; op_sel = OP_TAIL; end
      ST_PAD_CHK: begin core_start = (pos_r >= 7'd112); op_sel = OP_TAIL; end
      ST_LEN_GO:  begin core_start = 1'b1; op_sel = OP_TAIL; end
      ST_OUT_GO:  begin core_start = 1'b1; op_sel = OP_OUTER; end
      ST_IN_GO:   begin core_start = 1'b1; op_sel = OP_INNER; end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    case (st_r)
      ST_IDLE: if (head.valid) st_nxt = ST_ITEM;
      ST_ITEM: begin
        if (item_r.action == ACT_PASSWORD) begin
          if (item_r.has_byte) begin
            if (pw_need) begin
              st_nxt = ST_WAIT; ret_nxt = ST_PUT;
            end else begin
              st_nxt = ST_PUT;
            end
          end else begin
            st_nxt = item_r.segment_last ? ST_CLOSE : ST_IDLE;
          end
        end else begin
          st_nxt = item_r.segment_last ? ST_DRV : ST_IDLE;
        end
      end
      ST_PUT: st_nxt = item_r.segment_last ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: begin
        if (pw_long) begin
          if (pw_rem == 7'd0) begin
            st_nxt = ST_WAIT; ret_nxt = ST_CL_PAD;
          end else begin
            st_nxt = ST_CL_PAD;
          end
        end else begin
          st_nxt = ST_IPAD;
        end
      end
      ST_CL_PAD: st_nxt = ST_CL_CHK;
      ST_CL_CHK: begin
        if (pw_rem >= 7'd112) begin
          st_nxt = ST_WAIT; ret_nxt = ST_CL_LEN;
        end else begin
          st_nxt = ST_CL_LEN;
        end
      end
      ST_CL_LEN:  st_nxt = ST_CL_GO;
      ST_CL_GO:   begin st_nxt = ST_WAIT; ret_nxt = ST_IPAD; end
      ST_IPAD:    begin st_nxt = ST_WAIT; ret_nxt = ST_OPAD; end
      ST_OPAD:    begin st_nxt = ST_WAIT; ret_nxt = ST_PWCLR; end
      ST_PWCLR:   st_nxt = ST_IDLE;
      ST_DRV:     st_nxt = (blocks == 4'd0) ? ST_DONE : ST_BLK;
      ST_BLK:     st_nxt = ST_RD;
      ST_RD:      st_nxt = (idx_r == msg_len) ? ST_PAD : ST_WR;
      ST_WR:      st_nxt = (pos_r == 7'd127) ? ST_TAIL_GO : ST_RD;
      ST_TAIL_GO: begin st_nxt = ST_WAIT; ret_nxt = ST_RD; end
      ST_PAD:     st_nxt = ST_PAD_CHK;
      ST_PAD_CHK: begin
        if (pos_r >= 7'd112) begin
          st_nxt = ST_WAIT; ret_nxt = ST_LEN;
        end else begin
          st_nxt = ST_LEN;
        end
      end
      ST_LEN:     st_nxt = ST_LEN_GO;
      ST_LEN_GO:  begin st_nxt = ST_WAIT; ret_nxt = ST_OUT_GO; end
      ST_OUT_GO:  begin st_nxt = ST_WAIT; ret_nxt = ST_ACC; end
      ST_ACC:     st_nxt = (ic_r < iter_count) ? ST_IN_GO : ST_EMIT;
      ST_IN_GO:   begin st_nxt = ST_WAIT; ret_nxt = ST_OUT_GO; end
      ST_EMIT: begin
        if (j_r == 3'd7) begin
          st_nxt = (bnum_r == blocks) ? ST_DONE : ST_BLK;
        end
      end
      ST_DONE:    st_nxt = ST_IDLE;
      ST_WAIT:    if (core_done) st_nxt = ret_r;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // control and password state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      op_r        <= OP_PW;
      kb_r        <= '0;
      chain_r     <= SHA_IV;
      pwc_r       <= '0;
      longk_r     <= 1'b0;
      sc_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= emit_now;
      if (core_start) op_r <= op_sel;
      case (st_r)
        ST_ITEM: begin
          if (item_r.action == ACT_SALT && item_r.has_byte) begin
            if (sc_room) sc_r <= sc_r + 1'b1;
            else ovf_r <= 1'b1;
          end
        end
        ST_PUT: begin
          kb_r  <= put_byte(kb_r, pw_rem, item_r.data_byte);
          pwc_r <= pwc_r + 32'd1;
        end
        ST_CL_PAD: kb_r <= put_byte(kb_r, pw_rem, PAD_MARK);
        ST_CL_LEN: kb_r[15] <= 64'({pwc_r, 3'b000});
        ST_CL_GO:  longk_r <= 1'b1;
        ST_PWCLR: begin
          kb_r    <= '0;
          chain_r <= SHA_IV;
          pwc_r   <= '0;
          longk_r <= 1'b0;
        end
        ST_DONE: begin
          sc_r  <= '0;
          ovf_r <= 1'b0;
        end
        ST_WAIT: begin
          if (core_done && op_r == OP_PW) begin
            chain_r <= digest;
            kb_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // derivation datapath
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && head.valid) item_r <= head.item;
    case (st_r)
      ST_WAIT: begin
        if (core_done) begin
          case (op_r)
            OP_IPAD:  imid_r <= digest;
            OP_OPAD:  omid_r <= digest;
            OP_TAIL: begin
              inner_r <= digest;
              msg_r   <= '0;
              pos_r   <= '0;
            end
            OP_OUTER: u_r <= digest;
            OP_INNER: inner_r <= digest;
            default: ;
          endcase
        end
      end
      ST_DRV: bnum_r <= 4'd1;
      ST_BLK: begin
        inner_r <= imid_r;
        msg_r   <= '0;
        pos_r   <= '0;
        idx_r   <= '0;
        ic_r    <= 32'd1;
        first_r <= 1'b1;
      end
      ST_WR: begin
        msg_r <= put_byte(msg_r, pos_r, salt_byte);
        pos_r <= pos_r + 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      ST_PAD: msg_r <= put_byte(msg_r, pos_r, PAD_MARK);
      ST_LEN: msg_r[15] <= (64'(msg_len) + 64'd128) << 3;
      ST_ACC: begin
        t_r     <= first_r ? u_r : (t_r ^ u_r);
        first_r <= 1'b0;
        if (ic_r < iter_count) ic_r <= ic_r + 32'd1;
        else j_r <= '0;
      end
      ST_EMIT: begin
        j_r <= j_r + 1'b1;
        if (j_r == 3'd7 && bnum_r != blocks) bnum_r <= bnum_r + 4'd1;
      end
      default: ;
    endcase
    // result beat; bytes past the key are cleared
    if (emit_now) begin
      out_vb_r   <= (left > 10'd8) ? 4'd8 : left[3:0];
      out_word_r <= t_r[j_r] & ~(64'hFFFF_FFFF_FFFF_FFFF >>
                    {((left > 10'd8) ? 4'd8 : left[3:0]), 3'b000});
      out_last_r <= (left <= 10'd8);
      out_ovf_r  <= ovf_r;
    end
  end

  pbkdf_sha_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .h_in   (core_h),
    .blk_in (core_blk),
    .done   (core_done),
    .digest (digest)
  );

  pbkdf_ram #(.WIDTH(8), .DEPTH(SALT_BYTES)) u_salt (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sc_r[AW-1:0]),
    .wdata (item_r.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_key_word      = out_word_r;
  assign out_valid_bytes   = out_vb_r;
  assign out_result_last   = out_last_r;
  assign out_salt_overflow = out_ovf_r;

  `PBK_ASSERT_NXT(a_emit_only, st_r != ST_EMIT, !out_valid_r, "result outside emit")
  `PBK_ASSERT_IMP(a_salt_bound, 1'b1, sc_r <= SCW'(SALT_BYTES), "salt count overrun")
  `PBK_ASSERT_NXT(a_wait_hold, st_r == ST_WAIT && !core_done, st_r == ST_WAIT, "left wait early")

endmodule

// ===== hdl/pbkdf2_hmac_sha512_key_derivation_unit.sv =====
// PBKDF2 with HMAC-SHA-512. Items (password bytes, then salt bytes) are taken
// whenever busy is low, one per cycle, into a four-entry queue; busy rises only
// when that queue is full. All work is done by one SHA-512 compressor running
// one round per cycle. A password byte passes through ST_IDLE, ST_ITEM and
// ST_PUT, plus one compression at each 128-byte boundary; a salt byte passes
// through ST_IDLE and ST_ITEM. Closing the password takes two compressions (up
// to four for a password over 128 bytes). Closing the salt runs the derivation:
// per 64-byte output block the message (salt plus 4 bytes) is loaded byte by
// byte through ST_RD and ST_WR, then come 1-3 tail compressions plus
// 2*iteration_count-1 further compressions, then the key words leave. Result
// words are strobed by out_valid for one cycle each and cannot be held off.
module pbkdf2_hmac_sha512_key_derivation_unit import pbkdf_pkg::*; #(
  parameter int SALT_BYTES    = 256,
  parameter int MAX_KEY_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_segment_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [63:0] out_key_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_result_last,
  output logic        out_salt_overflow
);

  logic [31:0] iter_r;
  logic [9:0]  keylen_r;
  item_t       in_item;
  qhead_t      head;
  logic        pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r   <= ITER_RESET;
      keylen_r <= KEYLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ITER:   iter_r   <= cfg_wdata;
        CFG_KEYLEN: keylen_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{action: in_action, data_byte: in_data_byte,
                     has_byte: in_has_byte, segment_last: in_segment_last};

  pbkdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .pop     (pop),
    .head    (head)
  );

  pbkdf_back #(.SALT_BYTES(SALT_BYTES), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .iter_count        (iter_r),
    .key_len           (keylen_r),
    .out_valid         (out_valid),
    .out_key_word      (out_key_word),
    .out_valid_bytes   (out_valid_bytes),
    .out_result_last   (out_result_last),
    .out_salt_overflow (out_salt_overflow)
  );

endmodule
